>>> rtl/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg: shared types for the bounded ordered list engine
// Opcode and status codes, the key type and the control beat that the top
// level broadcasts to every list cell.
// ----------------------------------------------------------------------------
package bole_pkg;

    // Stored and compared key, signed two's complement
    typedef logic signed [31:0] t_key;

    // Command opcodes
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_INSERT = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Control broadcast to all cells
    typedef struct packed {
        logic cmp_en;   // latch compare result against cmp_key
        logic upd_en;   // apply the write pattern this cycle
        logic is_app;   // append at tail
        logic is_ins;   // ordered insert
        t_key cmp_key;  // key of the beat being accepted
        t_key new_key;  // key of the beat being applied
    } t_cell_ctl;

endpackage

>>> rtl/bole_cell.sv
// ----------------------------------------------------------------------------
// bole_cell: one slot of the ordered list
// Holds one key, compares it against an incoming key, and on update either
// keeps its key, takes the left neighbor's key (shift toward tail) or takes
// the new key. The found flag ripples from head to tail through the row.
// ----------------------------------------------------------------------------
module bole_cell
    import bole_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  t_key             i_left_key,
    input  logic             i_found,
    output logic             o_found,
    output t_key             o_key
);

    t_key r_key;
    logic r_ge;     // stored key >= incoming key
    logic w_valid;
    logic w_at_end;
    logic w_hit;
    logic w_take_new;
    logic w_take_left;

    // Slot position relative to the current fill level
    assign w_valid  = (i_count > CNT_W'(INDEX));
    assign w_at_end = (i_count == CNT_W'(INDEX));
    assign w_hit    = w_valid & r_ge;

    // First hit from the head wins; everything after it shifts
    assign o_found = i_found | w_hit;

    // Write pattern for this slot
    assign w_take_left = i_ctl.is_ins & i_found;
    assign w_take_new  = i_ctl.is_ins ? (!i_found & (w_hit | w_at_end))
                                      : (i_ctl.is_app & w_at_end);

    // Compare latch, loaded on the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_ge <= !(r_key < i_ctl.cmp_key);
        end
    end

    // Key storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd_en) begin
            if (w_take_left) begin
                r_key <= i_left_key;
            end else if (w_take_new) begin
                r_key <= i_ctl.new_key;
            end
        end
    end

    assign o_key = r_key;

endmodule

>>> rtl/bounded_ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top: ordered key list with fixed capacity
// Command-style engine over a row of list cells: append, remove tail and
// ordered insert, one status beat per command.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (opcode, key) is taken at a rising edge with start high
//   and busy low. busy is high for one cycle after each accepted beat, so a
//   new command can be taken while the previous one is still in flight.
//   Cycle after accept: every cell has latched its compare against the key;
//   the found flag ripples along the cell row and the cells shift or load.
//   Next cycle: head is read from the first cell and the tail through a
//   one-hot select over the row; the result registers load.
//   Following cycle: o_strobe is high for one cycle with status, count, head
//   and tail.
//   The found ripple across the row runs in the update cycle, after the
//   parallel compare has been latched.
//   There is no back-pressure on the result side; results cannot be held.
//   Reset (i_rst_n low, synchronous) empties the list and drops any command
//   in flight. Key storage is not cleared; slots beyond the count are never
//   reported.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top
    import bole_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic [1:0]              i_opcode,
    input  logic signed [31:0]      i_key,
    output logic                    busy,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [CNT_W-1:0]        o_entry_count,
    output logic signed [31:0]      o_head_key,
    output logic signed [31:0]      o_tail_key
);

    // Control state
    logic             r_busy;
    logic             r_pend;
    logic             r_strobe;
    logic [CNT_W-1:0] r_count;
    // Beat being applied
    t_op              r_op;
    t_key             r_key;
    t_status          r_stat;
    // Result registers
    t_status          r_o_stat;
    logic [CNT_W-1:0] r_o_count;
    t_key             r_o_head;
    t_key             r_o_tail;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_is_app;
    logic             w_is_ins;
    logic             w_write;
    t_status          n_stat;
    logic [CNT_W-1:0] n_count;
    t_key             n_tail;
    t_cell_ctl        w_ctl;

    logic             w_found [CAPACITY+1];
    t_key             w_key   [CAPACITY];
    t_key             w_tail_part [CAPACITY];

    assign w_accept = start & !r_busy;
    assign busy     = r_busy;

    // Decode of the beat in the update cycle
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_is_app = (r_op == OP_APPEND);
    assign w_is_ins = (r_op == OP_INSERT);
    assign w_write  = r_busy & !w_full & (w_is_app | w_is_ins);

    // Status and next count
    always_comb begin
        n_stat  = ST_OK;
        n_count = r_count;
        case (r_op)
            OP_APPEND, OP_INSERT: begin
                if (w_full) begin
                    n_stat = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (w_empty) begin
                    n_stat = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_stat = ST_OK;
            end
        endcase
    end

    // Cell broadcast
    always_comb begin
        w_ctl.cmp_en  = w_accept;
        w_ctl.upd_en  = w_write;
        w_ctl.is_app  = w_is_app;
        w_ctl.is_ins  = w_is_ins;
        w_ctl.cmp_key = i_key;
        w_ctl.new_key = r_key;
    end

    // Cell row, head at index 0
    assign w_found[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_key w_left;

        if (i == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body
            assign w_left = w_key[i-1];
        end

        bole_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_left_key (w_left),
            .i_found    (w_found[i]),
            .o_found    (w_found[i+1]),
            .o_key      (w_key[i])
        );

        // Tail select: slot count-1
        assign w_tail_part[i] = (r_count == CNT_W'(i + 1)) ? w_key[i] : '0;
    end

    // OR over the one-hot masked slots
    always_comb begin
        n_tail = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            n_tail = n_tail | w_tail_part[i];
        end
    end

    // Sequencing and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_busy   <= w_accept;
            r_pend   <= r_busy;
            r_strobe <= r_pend;
            if (r_busy) begin
                r_count <= n_count;
            end
        end
    end

    // Beat capture and status
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_op'(i_opcode);
            r_key <= i_key;
        end
        if (r_busy) begin
            r_stat <= n_stat;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_o_stat  <= r_stat;
            r_o_count <= r_count;
            r_o_head  <= w_empty ? t_key'(0) : w_key[0];
            r_o_tail  <= n_tail;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_o_stat;
    assign o_entry_count = r_o_count;
    assign o_head_key    = r_o_head;
    assign o_tail_key    = r_o_tail;

`ifndef SYNTHESIS
    // Fill level stays within capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    // Busy lasts exactly one cycle per beat
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held longer than one cycle");

    // Every accepted beat yields a result strobe
    a_strobe_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##2 r_strobe)
        else $error("missing result strobe");

    // Full status only when the list is at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_o_stat == ST_FULL) |-> (r_o_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    // Empty status only with an empty list
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_o_stat == ST_EMPTY) |-> (r_o_count == '0))
        else $error("empty status with entries present");
`endif

endmodule
